/* hw/rtl/qte_pkg.sv */
// Package for the quaternion to Euler angles unit.
// Constants, CORDIC arctangent table and the per-stage item record type.
// No dependencies.
package qte_pkg;

    localparam int CORDIC_STEPS    = 16;
    localparam int ANGLE_FRAC_BITS = 13;

    localparam int DW = 40;   // CORDIC x/y datapath width
    localparam int ZW = 34;   // angle accumulator width, Q2.30 plus headroom
    localparam int SH = 30 - ANGLE_FRAC_BITS;

    localparam logic signed [ZW-1:0] HALF_PI_Q30 = ZW'(64'sd1686629713);
    localparam logic signed [ZW-1:0] PI_Q30      = ZW'(64'sd3373259426);
    localparam logic signed [ZW-1:0] RND_Q30     = ZW'(64'sd1 <<< (SH - 1));
    localparam logic signed [ZW-1:0] LIM_PI      = (PI_Q30 + RND_Q30) >>> SH;
    localparam logic signed [ZW-1:0] LIM_HPI     = (HALF_PI_Q30 + RND_Q30) >>> SH;

    localparam logic signed [DW-1:0] ONE_Q28 = DW'(64'sd1 <<< 28);

    // atan(2^-i) * 2^30, truncated
    function automatic logic signed [ZW-1:0] atan_tab(input logic [4:0] i);
        logic [31:0] v;
        unique case (i)
            5'd0:  v = 32'h3243F6A8;
            5'd1:  v = 32'h1DAC6705;
            5'd2:  v = 32'h0FADBAFC;
            5'd3:  v = 32'h07F56EA6;
            5'd4:  v = 32'h03FEAB76;
            5'd5:  v = 32'h01FFD55B;
            5'd6:  v = 32'h00FFFAAA;
            5'd7:  v = 32'h007FFF55;
            5'd8:  v = 32'h003FFFEA;
            5'd9:  v = 32'h001FFFFD;
            5'd10: v = 32'h000FFFFF;
            5'd11: v = 32'h0007FFFF;
            5'd12: v = 32'h0003FFFF;
            5'd13: v = 32'h0001FFFF;
            5'd14: v = 32'h0000FFFF;
            5'd15: v = 32'h00007FFF;
            5'd16: v = 32'h00003FFF;
            5'd17: v = 32'h00001FFF;
            5'd18: v = 32'h00000FFF;
            5'd19: v = 32'h000007FF;
            5'd20: v = 32'h000003FF;
            5'd21: v = 32'h000001FF;
            5'd22: v = 32'h000000FF;
            5'd23: v = 32'h0000007F;
            default: v = 32'h0;
        endcase
        return ZW'(signed'({1'b0, v}));
    endfunction

    typedef struct packed {
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic signed [ZW-1:0] z;
    } t_vec;

endpackage

/* hw/rtl/qte_cordic.sv */
// Pipelined vectoring CORDIC: one register stage per iteration plus a
// quadrant stage. Uses qte_pkg.
module qte_cordic (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic signed [qte_pkg::DW-1:0] i_x,
    input  logic signed [qte_pkg::DW-1:0] i_y,
    output logic                       o_valid,
    output logic signed [qte_pkg::ZW-1:0] o_z
);
    localparam int N = qte_pkg::CORDIC_STEPS;

    qte_pkg::t_vec r_v [N+1];
    logic          r_vld [N+1];
    qte_pkg::t_vec n_q;

    // quadrant pre-rotation; a zero vector keeps x and y at zero through all steps
    always_comb begin
        n_q.x = i_x;
        n_q.y = i_y;
        n_q.z = '0;
        if (i_x < 0) begin
            if (i_y >= 0) begin
                n_q.x = i_y;
                n_q.y = -i_x;
                n_q.z = qte_pkg::HALF_PI_Q30;
            end else begin
                n_q.x = -i_y;
                n_q.y = i_x;
                n_q.z = -qte_pkg::HALF_PI_Q30;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
        if (i_en) begin
            r_v[0] <= n_q;
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_step
        qte_pkg::t_vec n_v;
        logic          zero_in;
        assign zero_in = (r_v[g].x == 0) && (r_v[g].y == 0) && (r_v[g].z == 0)
                         && (g == 0);
        always_comb begin
            n_v = r_v[g];
            if (zero_in) begin
                n_v = r_v[g];
            end else if (r_v[g].y >= 0) begin
                n_v.x = r_v[g].x + (r_v[g].y >>> g);
                n_v.y = r_v[g].y - (r_v[g].x >>> g);
                n_v.z = r_v[g].z + qte_pkg::atan_tab(5'(g));
            end else begin
                n_v.x = r_v[g].x - (r_v[g].y >>> g);
                n_v.y = r_v[g].y + (r_v[g].x >>> g);
                n_v.z = r_v[g].z - qte_pkg::atan_tab(5'(g));
            end
        end
        // a zero vector is kept flagged by forcing y negative-free path:
        // once x=y=0 every later step leaves x,y at zero, only z moves,
        // so mark it by zeroing z at the end instead
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[g+1] <= r_vld[g];
            end
            if (i_en) begin
                r_v[g+1] <= n_v;
            end
        end
    end

    // x stays zero only for the zero vector (x grows otherwise)
    assign o_valid = r_vld[N];
    assign o_z     = (r_v[N].x == 0) ? '0 : r_v[N].z;
endmodule

/* hw/rtl/qte_isqrt.sv */
// Pipelined integer square root, two result bits per register stage (one in the last).
// Computes floor(sqrt(i_n)) of the 58-bit input. No dependencies.
module qte_isqrt (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [57:0]       i_n,
    output logic [28:0]       o_root
);
    localparam int B = 29;

    // stage boundaries; a register after every second bit and after the last
    logic [B:0][57:0] stg_n;
    logic [B:0][57:0] stg_res;

    assign stg_n[0]   = i_n;
    assign stg_res[0] = '0;

    for (genvar g = 0; g < B; g++) begin : g_bit
        localparam logic [57:0] BIT = 58'd1 << (2 * (B - 1 - g));
        logic [57:0] n_n, n_res;
        always_comb begin
            if (stg_n[g] >= stg_res[g] + BIT) begin
                n_n   = stg_n[g] - (stg_res[g] + BIT);
                n_res = (stg_res[g] >> 1) + BIT;
            end else begin
                n_n   = stg_n[g];
                n_res = stg_res[g] >> 1;
            end
        end
        if ((g % 2 == 1) || (g == B - 1)) begin : g_reg
            logic [57:0] r_n, r_res;
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_n   <= n_n;
                    r_res <= n_res;
                end
            end
            assign stg_n[g+1]   = r_n;
            assign stg_res[g+1] = r_res;
        end else begin : g_cmb
            assign stg_n[g+1]   = n_n;
            assign stg_res[g+1] = n_res;
        end
    end

    assign o_root = stg_res[B][28:0];
endmodule

/* hw/rtl/quaternion_to_euler_angles_unit.sv */
// Quaternion to ZYX Euler angles top level.
// Uses qte_pkg, qte_cordic and qte_isqrt.
//
// Takes one quaternion (w,x,y,z, signed Q1.14) per cycle and returns yaw and
// roll in signed Q3.13 and pitch in signed Q2.13 radians plus a pitch clamp
// flag. Fully pipelined: one item per cycle sustained while the output is not
// stalled. Stages: products, sums, clamp test and pitch square, 15 square root
// stages, CORDIC quadrant + iterations, output rounding. The whole pipe
// advances when the output register is empty or being taken; on stall every
// stage holds, so nothing is lost or repeated.
module quaternion_to_euler_angles_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // quat_w, quat_x, quat_y, quat_z
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // yaw_angle, pitch_angle, roll_angle, 1'b0 pad
    output logic        m_axis_tuser   // pitch_clamped
);
    localparam int DW = qte_pkg::DW;
    localparam int ZW = qte_pkg::ZW;
    localparam int SQD = 15; // square-root stage count (29 bits, a reg per 2)
    localparam int CD  = qte_pkg::CORDIC_STEPS + 1;

    logic en;
    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // stage 1: products
    logic signed [15:0] qw, qx, qy, qz;
    assign qw = s_axis_tdata[15:0];
    assign qx = s_axis_tdata[31:16];
    assign qy = s_axis_tdata[47:32];
    assign qz = s_axis_tdata[63:48];

    logic signed [31:0] r_wx, r_yz, r_xx, r_yy, r_wy, r_zx, r_wz, r_xy, r_zz;
    logic               r_v1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else if (en)  r_v1 <= s_axis_tvalid;
        if (en) begin
            r_wx <= qw * qx; r_yz <= qy * qz; r_xx <= qx * qx;
            r_yy <= qy * qy; r_wy <= qw * qy; r_zx <= qz * qx;
            r_wz <= qw * qz; r_xy <= qx * qy; r_zz <= qz * qz;
        end
    end

    // stage 2: sine and cosine terms, Q.28
    logic signed [DW-1:0] r_sr, r_cr, r_sp, r_sy, r_cy;
    logic                 r_v2;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else if (en)  r_v2 <= r_v1;
        if (en) begin
            r_sr <= 2 * (DW'(r_wx) + DW'(r_yz));
            r_cr <= qte_pkg::ONE_Q28 - 2 * (DW'(r_xx) + DW'(r_yy));
            r_sp <= 2 * (DW'(r_wy) - DW'(r_zx));
            r_sy <= 2 * (DW'(r_wz) + DW'(r_xy));
            r_cy <= qte_pkg::ONE_Q28 - 2 * (DW'(r_yy) + DW'(r_zz));
        end
    end

    // stage 3: |sp| squared for the root; clamp test goes into the delay line
    logic [DW-1:0] sp_abs;
    assign sp_abs = r_sp < 0 ? DW'(-r_sp) : DW'(r_sp);
    logic [57:0] r_rem;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rem  <= (58'd1 << 56) - 58'(sp_abs[28:0] * sp_abs[28:0]);
        end
    end

    // delay lines for roll/yaw sine and cosine, pitch sine, clamp flag and valid while the root settles
    logic signed [DW-1:0] r_dsr [SQD+1];
    logic signed [DW-1:0] r_dcr [SQD+1];
    logic signed [DW-1:0] r_dsy [SQD+1];
    logic signed [DW-1:0] r_dcy [SQD+1];
    logic signed [DW-1:0] r_dsp [SQD+1];
    logic                 r_dcl [SQD+1];
    logic                 r_dv  [SQD+1];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= SQD; k++) r_dv[k] <= 1'b0;
        end else if (en) begin
            r_dv[0] <= r_v2;
            for (int k = 1; k <= SQD; k++) r_dv[k] <= r_dv[k-1];
        end
        if (en) begin
            r_dsr[0] <= r_sr; r_dcr[0] <= r_cr; r_dsy[0] <= r_sy;
            r_dcy[0] <= r_cy; r_dsp[0] <= r_sp;
            r_dcl[0] <= (r_sp >= qte_pkg::ONE_Q28) || (r_sp <= -qte_pkg::ONE_Q28);
            for (int k = 1; k <= SQD; k++) begin
                r_dsr[k] <= r_dsr[k-1]; r_dcr[k] <= r_dcr[k-1];
                r_dsy[k] <= r_dsy[k-1]; r_dcy[k] <= r_dcy[k-1];
                r_dsp[k] <= r_dsp[k-1];
                r_dcl[k] <= r_dcl[k-1];
            end
        end
    end

    logic [28:0] root;
    qte_isqrt u_sqrt (.i_clk(i_clk), .i_en(en), .i_n(r_rem), .o_root(root));
    // root lines up with delay index SQD (rem at 0, plus 15 root stages)

    logic              v_r, v_y, v_p;
    logic signed [ZW-1:0] z_r, z_y, z_p;
    qte_cordic u_roll (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(r_dv[SQD]), .i_x(r_dcr[SQD]), .i_y(r_dsr[SQD]),
        .o_valid(v_r), .o_z(z_r));
    qte_cordic u_yaw (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(r_dv[SQD]), .i_x(r_dcy[SQD]), .i_y(r_dsy[SQD]),
        .o_valid(v_y), .o_z(z_y));
    qte_cordic u_pitch (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(r_dv[SQD]), .i_x(DW'({1'b0, root})), .i_y(r_dsp[SQD]),
        .o_valid(v_p), .o_z(z_p));

    // clamp flag and pitch sign follow the CORDIC depth
    logic r_ccl [CD];
    logic r_cps [CD];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ccl[0] <= r_dcl[SQD];
            r_cps[0] <= r_dsp[SQD] > 0;
            for (int k = 1; k < CD; k++) begin
                r_ccl[k] <= r_ccl[k-1];
                r_cps[k] <= r_cps[k-1];
            end
        end
    end

    function automatic logic signed [ZW-1:0] to_out(input logic signed [ZW-1:0] z,
                                                   input logic signed [ZW-1:0] lim);
        logic signed [ZW-1:0] r;
        r = (z + qte_pkg::RND_Q30) >>> qte_pkg::SH;
        if (r > lim)  r = lim;
        if (r < -lim) r = -lim;
        return r;
    endfunction

    logic signed [ZW-1:0] pz, ro, yo, po;
    assign pz = r_ccl[CD-1] ? (r_cps[CD-1] ? qte_pkg::HALF_PI_Q30
                                           : -qte_pkg::HALF_PI_Q30) : z_p;
    assign ro = to_out(z_r, qte_pkg::LIM_PI);
    assign yo = to_out(z_y, qte_pkg::LIM_PI);
    assign po = to_out(pz,  qte_pkg::LIM_HPI);

    logic r_ov;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (en)  r_ov <= v_r & v_y & v_p;
        if (en) begin
            m_axis_tdata <= {1'b0, ro[15:0], po[14:0], yo[15:0]};
            m_axis_tuser <= r_ccl[CD-1];
        end
    end
    assign m_axis_tvalid = r_ov;
endmodule

/* dv/quaternion_to_euler_angles_unit_tb.sv */
// Testbench for quaternion_to_euler_angles_unit: ZYX Euler angles from Q1.14 quaternions.
// Depends on the RTL top level only; holds its own CORDIC angle predictor and scoreboard.
// Directed corner quaternions, then random ones under several idle/stall mixes.
module quaternion_to_euler_angles_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_STEPS   = 16;
    localparam int FRAC_BITS = 13;
    localparam int RND_SHIFT = 30 - FRAC_BITS;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint ONE_Q28     = 64'sd1 <<< 28;
    localparam int PIPE_DEPTH  = 3 + 15 + N_STEPS + 1 + 1;

    localparam logic signed [15:0] Q_ZERO = 16'sd0;
    localparam logic signed [15:0] Q_ONE  = 16'sd16384;
    localparam logic signed [15:0] Q_NEG  = -16'sd16384;
    localparam logic signed [15:0] Q_HALF = 16'sd8192;
    localparam logic signed [15:0] Q_MH   = -16'sd8192;
    localparam logic signed [15:0] Q_H    = 16'sd11585;  // ~1/sqrt(2)
    localparam logic signed [15:0] Q_NH   = -16'sd11585;
    localparam logic signed [15:0] Q_M1   = -16'sd1;

    typedef struct packed {
        logic signed [15:0] yaw;
        logic signed [14:0] pitch;
        logic signed [15:0] roll;
        logic               clamped;
    } t_euler;

    // Floor shift of a signed value
    function automatic longint floor_shr(longint v, int n);
        if (v >= 0) return v >> n;
        return -(((-v) - 1) >> n) - 1;
    endfunction

    function automatic longint arctan_entry(int i);
        longint tab [24] = '{
            64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
            64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
            64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
            64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
            64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
            64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
        return tab[i];
    endfunction

    // Integer square root, bitwise restoring
    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // Vectoring CORDIC arctangent, Q2.30 angle
    function automatic longint vector_angle(longint y, longint x);
        longint z, t, xs, ys;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; z = HALF_PI_Q30;
            end else begin
                t = x; x = -y; y = t; z = -HALF_PI_Q30;
            end
        end
        for (int i = 0; i < N_STEPS && i < 24; i++) begin
            xs = floor_shr(x, i);
            ys = floor_shr(y, i);
            if (y >= 0) begin
                x += ys; y -= xs; z += arctan_entry(i);
            end else begin
                x -= ys; y += xs; z -= arctan_entry(i);
            end
        end
        return z;
    endfunction

    // Round half up to output fraction bits, saturate to +-lim
    function automatic longint round_angle(longint z, longint lim_q30);
        longint lim, r;
        lim = floor_shr(lim_q30 + (64'sd1 <<< (RND_SHIFT - 1)), RND_SHIFT);
        r = floor_shr(z + (64'sd1 <<< (RND_SHIFT - 1)), RND_SHIFT);
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return r;
    endfunction

    function automatic t_euler predict_euler(logic [63:0] q);
        longint w, x, y, z, sr, cr, sp, sy, cy, cp;
        longint unsigned sq;
        t_euler e;
        w = longint'($signed(q[15:0]));
        x = longint'($signed(q[31:16]));
        y = longint'($signed(q[47:32]));
        z = longint'($signed(q[63:48]));
        sr = 2 * (w * x + y * z);
        cr = ONE_Q28 - 2 * (x * x + y * y);
        sp = 2 * (w * y - z * x);
        sy = 2 * (w * z + x * y);
        cy = ONE_Q28 - 2 * (y * y + z * z);
        e.roll = 16'(round_angle(vector_angle(sr, cr), 2 * HALF_PI_Q30));
        e.yaw  = 16'(round_angle(vector_angle(sy, cy), 2 * HALF_PI_Q30));
        if (sp >= ONE_Q28 || sp <= -ONE_Q28) begin
            // pitch pinned at +-pi/2
            e.clamped = 1'b1;
            e.pitch = 15'(round_angle(sp > 0 ? HALF_PI_Q30 : -HALF_PI_Q30, HALF_PI_Q30));
        end else begin
            e.clamped = 1'b0;
            sq = longint'(sp < 0 ? -sp : sp);
            cp = longint'(int_sqrt((64'd1 << 56) - sq * sq));
            e.pitch = 15'(round_angle(vector_angle(sp, cp), HALF_PI_Q30));
        end
        return e;
    endfunction

    class euler_scoreboard;
        t_euler pending[$];
        int     errors;

        function void note_quat(logic [63:0] q);
            pending = {pending, predict_euler(q)};
        endfunction

        function void check_angles(logic [47:0] data, logic flag);
            t_euler e;
            if (pending.size() == 0) begin
                $error("unexpected result item %h", data);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (data[15:0] !== e.yaw) begin
                $error("yaw_angle: expected %0d, got %0d", e.yaw, $signed(data[15:0]));
                errors++;
            end
            if (data[30:16] !== e.pitch) begin
                $error("pitch_angle: expected %0d, got %0d", e.pitch, $signed(data[30:16]));
                errors++;
            end
            if (data[46:31] !== e.roll) begin
                $error("roll_angle: expected %0d, got %0d", e.roll, $signed(data[46:31]));
                errors++;
            end
            if (flag !== e.clamped) begin
                $error("pitch_clamped: expected %0d, got %0d", e.clamped, flag);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;  // quat_w, quat_x, quat_y, quat_z
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;       // yaw, pitch, roll, pad
    logic        m_axis_tuser;       // pitch_clamped

    int idle_pct  = 0;   // sender gap chance, percent
    int stall_pct = 0;   // receiver stall chance, percent
    euler_scoreboard angle_sb = new();

    quaternion_to_euler_angles_unit dut (.*);

    always #5 i_clk = ~i_clk;

    // Receiver: randomly stalled ready; checks each accepted result
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            angle_sb.check_angles(m_axis_tdata, m_axis_tuser);
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Drive one quaternion and hold it until accepted
    task automatic send_quat(logic signed [15:0] w, logic signed [15:0] x,
                             logic signed [15:0] y, logic signed [15:0] z);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {z, y, x, w};
        do @(posedge i_clk); while (!s_axis_tready);
        angle_sb.note_quat({z, y, x, w});
    endtask

    function automatic logic signed [15:0] rand_comp();
        return 16'($signed($urandom_range(32768)) - 16384);
    endfunction

    // Near-unit quaternion: random direction scaled close to norm one
    task automatic send_unit_quat();
        real a, b, c, d, n;
        a = $signed($urandom_range(2000)) - 1000;
        b = $signed($urandom_range(2000)) - 1000;
        c = $signed($urandom_range(2000)) - 1000;
        d = $signed($urandom_range(2000)) - 1000;
        n = $sqrt(a * a + b * b + c * c + d * d);
        if (n == 0.0) n = 1.0;
        send_quat(16'($rtoi(a / n * 16384.0)), 16'($rtoi(b / n * 16384.0)),
                  16'($rtoi(c / n * 16384.0)), 16'($rtoi(d / n * 16384.0)));
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: identity, extremes, gimbal lock both ways, zero vectors
        send_quat(Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO);
        send_quat(Q_NEG, Q_ZERO, Q_ZERO, Q_ZERO);
        send_quat(Q_ZERO, Q_ONE, Q_ZERO, Q_ZERO);   // roll = pi (atan2(0, negative))
        send_quat(Q_ZERO, Q_ZERO, Q_ONE, Q_ZERO);
        send_quat(Q_ZERO, Q_ZERO, Q_ZERO, Q_ONE);
        send_quat(Q_ZERO, Q_NEG, Q_ZERO, Q_ZERO);
        send_quat(Q_ZERO, Q_ZERO, Q_NEG, Q_ZERO);
        send_quat(Q_ZERO, Q_ZERO, Q_ZERO, Q_NEG);
        send_quat(Q_H, Q_ZERO, Q_H, Q_ZERO);        // pitch near +pi/2, just below the clamp
        send_quat(Q_H, Q_ZERO, Q_NH, Q_ZERO);       // pitch near -pi/2, just below the clamp
        send_quat(Q_ZERO, Q_H, Q_ZERO, Q_H);
        send_quat(Q_ZERO, Q_H, Q_ZERO, Q_NH);
        send_quat(Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO);  // zero vector
        send_quat(Q_ONE, Q_ONE, Q_ONE, Q_ONE);
        send_quat(Q_NEG, Q_NEG, Q_NEG, Q_NEG);
        send_quat(Q_ONE, Q_NEG, Q_ONE, Q_NEG);
        send_quat(Q_NEG, Q_ONE, Q_NEG, Q_ONE);
        send_quat(Q_HALF, Q_HALF, Q_HALF, Q_HALF);
        send_quat(Q_HALF, Q_MH, Q_HALF, Q_HALF);
        send_quat(Q_M1, Q_M1, Q_M1, Q_M1);
        send_quat(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);  // out of range words
        send_quat(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);

        // Random phases: none, sender idle, receiver stall, both light
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = (ph == 1) ? 50 : (ph == 3) ? 10 : 0;
            stall_pct = (ph == 2) ? 50 : (ph == 3) ? 10 : 0;
            for (int i = 0; i < 258; i++) begin
                case ($urandom_range(9))
                    0, 1:    send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
                    2:       send_quat(16'($urandom), 16'($urandom),
                                       16'($urandom), 16'($urandom));
                    default: send_unit_quat();
                endcase
            end
        end
        s_axis_tvalid <= 1'b0;
        stall_pct = 0;

        while (angle_sb.pending.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 10) @(posedge i_clk);
        if (angle_sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog
    initial begin
        #2ms;
        $display("Verification failed");
        $finish;
    end
endmodule
